FILE: rtl/rlim_pkg.sv
// Shared types, constants and the key hash for the per-client request and byte limiter.
// Used by rlim_ram and by the top level; depends on nothing else.
package rlim_pkg;

    localparam int MAX_CLIENTS = 256;
    localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int DEFAULT_WINDOW = 1000000000;

    // Configuration register indexes.
    localparam logic [1:0] REG_REQUEST_LIMIT = 2'd0;
    localparam logic [1:0] REG_BYTE_LIMIT    = 2'd1;
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd2;

    // Item kinds.
    localparam logic FUNC_ADMIT  = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_TABLE     = 2'd1,
        CAUSE_REQUEST   = 2'd2,
        CAUSE_BANDWIDTH = 2'd3
    } cause_t;

    typedef logic [IDX_W-1:0] idx_t;

    // One client entry as it sits in the table memory.
    typedef struct packed {
        logic [31:0] key;
        logic        req_started;
        logic [63:0] req_start;
        logic [31:0] req_used;
        logic        byte_started;
        logic [63:0] byte_start;
        logic [39:0] byte_used;
    } entry_t;

    // Home slot of a key: fold two index-wide slices and wrap into the table depth.
    function automatic idx_t rlim_hash(input logic [31:0] k);
        logic [IDX_W-1:0] f;
        logic [IDX_W:0]   t;
        begin
            f = k[IDX_W-1:0] ^ k[2*IDX_W-1:IDX_W];
            t = {1'b0, f};
            if (t >= (IDX_W+1)'(MAX_CLIENTS))
            begin
                t = t - (IDX_W+1)'(MAX_CLIENTS);
            end
            return t[IDX_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/rlim_ram.sv
// Client table memory: one write port, one read port with registered read data.
// Depends on rlim_pkg for the entry type and depth.
module rlim_ram
(
    input  logic              clk,
    input  logic              we,
    input  rlim_pkg::idx_t    waddr,
    input  rlim_pkg::entry_t  wdata,
    input  logic              re,
    input  rlim_pkg::idx_t    raddr,
    output rlim_pkg::entry_t  rdata
);
    import rlim_pkg::*;

    entry_t mem [MAX_CLIENTS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/per_client_request_byte_limiter.sv
// Top level of the per-client request and byte limiter.
// Depends on rlim_pkg and rlim_ram.
//
// The block keeps one fixed counting window for requests and one for bytes per
// client key, in a table of MAX_CLIENTS entries held in a single synchronous
// memory. An admit item gets one result item (admitted flag, reject cause and
// both running reject totals); a record item charges response bytes and gives
// no result. An admit that needs no table access (limits off or anonymous
// client) goes straight to the result stage, and a record that is skipped
// goes back to idle. Otherwise the key is looked up by open addressing from
// a hashed home slot: each probe of the memory issues the read and then
// compares the returned key, and an absent key is inserted at the first free
// slot met. After the entry is found, ST_CALC1 computes the window restarts,
// ST_CALC2 computes the charges and writes the entry back, and an admit then
// loads the result in ST_DONE. At worst a key is found only at the last of
// MAX_CLIENTS probes.
// One item is in flight at a time; the next item is taken once the current one
// has handed its result to the output register, so a result may wait there
// while the next item already works. The table is empty after reset.
module per_client_request_byte_limiter
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: client_key[31:0], byte_count[63:32], time_ns[127:64]
    input  logic [127:0]  s_axis_tdata,
    // tuser: func[0], client_present[1]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: admitted[0], reject_cause[2:1], request_rejects[34:3],
    // bandwidth_rejects[66:35], zero fill[71:67]
    output logic [71:0]   m_axis_tdata,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [39:0]   cfg_data
);
    import rlim_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CMP,
        ST_CALC1,
        ST_CALC2,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [31:0]   req_limit_reg;
    logic [39:0]   byte_limit_reg;
    logic [31:0]   window_reg;

    logic          func_reg;
    logic [31:0]   key_reg;
    logic [31:0]   bytes_reg;
    logic [63:0]   now_reg;

    idx_t          idx_reg;
    idx_t          probes_reg;
    logic          valid_reg [MAX_CLIENTS];
    entry_t        ent_reg;
    logic          req_rst_reg;
    logic          byte_rst_reg;

    logic          res_adm_reg;
    cause_t        res_cause_reg;
    logic [31:0]   req_total_reg;
    logic [31:0]   bw_total_reg;

    logic          out_valid_reg;
    logic [71:0]   out_data_reg;

    entry_t        rd_data;
    entry_t        wr_data;
    logic          ram_re;
    logic          ram_we;

    // Charge arithmetic on the entry latched in ent_reg.
    logic [31:0]   req_used_eff;
    logic [39:0]   byte_used_eff;
    logic [39:0]   bytes40;
    logic          req_on;
    logic          byte_on;
    logic          req_fail;
    logic          byte_fail;
    logic          out_free;
    idx_t          idx_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign ram_re = (state_reg == ST_LOOKUP) && valid_reg[idx_reg];
    assign ram_we = (state_reg == ST_CALC2);
    assign idx_inc = (idx_reg == IDX_W'(MAX_CLIENTS - 1)) ? '0 : idx_reg + 1'b1;

    rlim_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        bytes40       = {8'd0, bytes_reg};
        req_on        = (req_limit_reg != 32'd0) && (func_reg == FUNC_ADMIT);
        byte_on       = (byte_limit_reg != 40'd0);
        req_used_eff  = req_rst_reg ? 32'd0 : ent_reg.req_used;
        byte_used_eff = byte_rst_reg ? 40'd0 : ent_reg.byte_used;
        req_fail      = req_on && (req_used_eff >= req_limit_reg);
        byte_fail     = byte_on && ((bytes40 > byte_limit_reg)
                        || (byte_used_eff > byte_limit_reg - bytes40));

        wr_data = ent_reg;
        if (req_on)
        begin
            wr_data.req_started = 1'b1;
            wr_data.req_start   = req_rst_reg ? now_reg : ent_reg.req_start;
            wr_data.req_used    = req_fail ? req_used_eff : req_used_eff + 32'd1;
        end
        // The byte window is charged only when the request charge passed.
        if (byte_on && !req_fail)
        begin
            wr_data.byte_started = 1'b1;
            wr_data.byte_start   = byte_rst_reg ? now_reg : ent_reg.byte_start;
            wr_data.byte_used    = byte_fail ? byte_used_eff : byte_used_eff + bytes40;
            // A byte denial on an admit hands the request token back.
            if (byte_fail && (func_reg == FUNC_ADMIT) && (wr_data.req_used != 32'd0))
            begin
                wr_data.req_used = wr_data.req_used - 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_limit_reg  <= '0;
            byte_limit_reg <= '0;
            window_reg     <= 32'(DEFAULT_WINDOW);
            req_total_reg  <= '0;
            bw_total_reg   <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_CLIENTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REQUEST_LIMIT: req_limit_reg  <= cfg_data[31:0];
                    REG_BYTE_LIMIT:    byte_limit_reg <= cfg_data;
                    REG_WINDOW_LENGTH: window_reg     <= cfg_data[31:0];
                    default:           ;
                endcase
            end

            // The result stage refills the output register itself.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg    <= s_axis_tuser[0];
                        key_reg     <= s_axis_tdata[31:0];
                        bytes_reg   <= s_axis_tdata[63:32];
                        now_reg     <= s_axis_tdata[127:64];
                        idx_reg     <= rlim_hash(s_axis_tdata[31:0]);
                        probes_reg  <= '0;
                        res_adm_reg <= 1'b1;
                        res_cause_reg <= CAUSE_NONE;
                        if (s_axis_tuser[0] == FUNC_RECORD)
                        begin
                            if (byte_limit_reg == 40'd0 || !s_axis_tuser[1]
                                || s_axis_tdata[63:32] == 32'd0)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_LOOKUP;
                            end
                        end
                        else if ((req_limit_reg == 32'd0 && byte_limit_reg == 40'd0)
                                 || !s_axis_tuser[1])
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_LOOKUP;
                        end
                    end
                end

                ST_LOOKUP:
                begin
                    if (valid_reg[idx_reg])
                    begin
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        // Free slot ends the probe chain: insert a fresh entry.
                        valid_reg[idx_reg] <= 1'b1;
                        ent_reg   <= '{key: key_reg, default: '0};
                        state_reg <= ST_CALC1;
                    end
                end

                ST_CMP:
                begin
                    if (rd_data.key == key_reg)
                    begin
                        ent_reg   <= rd_data;
                        state_reg <= ST_CALC1;
                    end
                    else if (probes_reg == IDX_W'(MAX_CLIENTS - 1))
                    begin
                        // Every slot holds another key: the table is full.
                        if (func_reg == FUNC_ADMIT)
                        begin
                            res_adm_reg   <= 1'b0;
                            res_cause_reg <= CAUSE_TABLE;
                            req_total_reg <= req_total_reg + 32'd1;
                            state_reg     <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        probes_reg <= probes_reg + 1'b1;
                        idx_reg    <= idx_inc;
                        state_reg  <= ST_LOOKUP;
                    end
                end

                ST_CALC1:
                begin
                    req_rst_reg  <= !ent_reg.req_started
                                    || ((now_reg - ent_reg.req_start) >= {32'd0, window_reg});
                    byte_rst_reg <= !ent_reg.byte_started
                                    || ((now_reg - ent_reg.byte_start) >= {32'd0, window_reg});
                    state_reg    <= ST_CALC2;
                end

                ST_CALC2:
                begin
                    if (func_reg == FUNC_ADMIT)
                    begin
                        if (req_fail)
                        begin
                            res_adm_reg   <= 1'b0;
                            res_cause_reg <= CAUSE_REQUEST;
                            req_total_reg <= req_total_reg + 32'd1;
                        end
                        else if (byte_fail)
                        begin
                            res_adm_reg   <= 1'b0;
                            res_cause_reg <= CAUSE_BANDWIDTH;
                            bw_total_reg  <= bw_total_reg + 32'd1;
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {5'd0, bw_total_reg, req_total_reg,
                                          res_cause_reg, res_adm_reg};
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result is admitted exactly when it carries no reject cause.
    a_cause_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == CAUSE_NONE)))
        else $error("admitted flag disagrees with reject cause");

    // A new result only ever comes from the result stage.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) && $rose(m_axis_tvalid))
        |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the result stage");

    // A key compare always follows a table read issued in the cycle before.
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> $past(ram_re))
        else $error("key compare without a table read");

    // The table is written back only after the window restarts were computed.
    a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(state_reg == ST_CALC1))
        else $error("table write out of order");

endmodule
